// ===== rtl/sceu_pkg.sv =====
// Shared types and constants for the scalar execute unit.
// Used by the channel interfaces and by every module of the block.
`default_nettype none

package sceu_pkg;

	localparam int unsigned MEM_WORDS = 65536;
	localparam int unsigned MEM_AW    = $clog2(MEM_WORDS);
	localparam int unsigned XLEN      = 64;
	localparam int unsigned HALF      = XLEN / 2;
	localparam int unsigned NREGS     = 16;
	localparam int unsigned RAW       = $clog2(NREGS);
	localparam int unsigned ACT_W     = 4;
	localparam int unsigned IMM_W     = 4;
	localparam int unsigned OFF_W     = 20;
	localparam int unsigned FL_W      = 13;
	localparam int unsigned RB_W      = 12;
	localparam int unsigned UNIT_SH   = 8;
	localparam int unsigned BOUND_W   = FL_W + UNIT_SH;
	localparam int unsigned PADDR_W   = BOUND_W + 1;
	localparam int unsigned CFG_DW    = 20;
	localparam int unsigned CFG_IW    = 2;
	localparam int unsigned QDEPTH    = 2;
	localparam int unsigned QAW       = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

	typedef enum logic [ACT_W-1:0] {
		ACT_JMPZ    = 4'd0,
		ACT_JMPP    = 4'd1,
		ACT_SETK    = 4'd2,
		ACT_LOADRR  = 4'd3,
		ACT_STORERR = 4'd4,
		ACT_ADDOC   = 4'd5,
		ACT_SUBIMM  = 4'd6,
		ACT_NEG     = 4'd7,
		ACT_ADDIMM  = 4'd8,
		ACT_MUL     = 4'd9,
		ACT_LOADK   = 4'd10
	} action_t;

	typedef enum logic [3:0] {
		OP_NOP,
		OP_JMPZ,
		OP_JMPP,
		OP_SETK,
		OP_LOADRR,
		OP_STORERR,
		OP_ADDOC,
		OP_SUBIMM,
		OP_NEG,
		OP_ADDIMM,
		OP_MUL,
		OP_LOADK
	} op_t;

	typedef logic [CFG_IW-1:0] cfg_idx_t;
	localparam cfg_idx_t CFG_FIELD_LENGTH     = 2'd0;
	localparam cfg_idx_t CFG_RELOCATION_BASE  = 2'd1;
	localparam cfg_idx_t CFG_EXCHANGE_ADDRESS = 2'd2;

	typedef struct packed {
		op_t              op;
		logic [RAW-1:0]   reg_i;
		logic [RAW-1:0]   reg_j;
		logic [RAW-1:0]   reg_k;
		logic [IMM_W-1:0] small_imm;
		logic [OFF_W-1:0] long_offset;
		logic             wr_en;
		logic [RAW-1:0]   wr_idx;
	} dec_t;

	typedef struct packed {
		logic [FL_W-1:0]  field_length;
		logic [RB_W-1:0]  relocation_base;
		logic [OFF_W-1:0] exchange_address;
	} cfg_t;

	typedef struct packed {
		logic fault;
	} stat_t;

	typedef enum logic [2:0] {
		BK_READ,
		BK_EXEC,
		BK_LOAD,
		BK_STORE,
		BK_MUL_X1,
		BK_MUL_X2,
		BK_MUL_FIN
	} bk_state_t;

endpackage

`default_nettype wire

// ===== rtl/sceu_ifs.sv =====
// Valid/ready channel interfaces for instructions and results.
// Depends on sceu_pkg for field widths.
`default_nettype none

interface sceu_instr_if;
	logic                         valid;
	logic                         ready;
	logic [sceu_pkg::ACT_W-1:0]   action;
	logic [sceu_pkg::RAW-1:0]     reg_i;
	logic [sceu_pkg::RAW-1:0]     reg_j;
	logic [sceu_pkg::RAW-1:0]     reg_k;
	logic [sceu_pkg::IMM_W-1:0]   small_imm;
	logic [sceu_pkg::OFF_W-1:0]   long_offset;

	modport source (output valid, action, reg_i, reg_j, reg_k, small_imm, long_offset,
		input ready);
	modport sink (input valid, action, reg_i, reg_j, reg_k, small_imm, long_offset,
		output ready);
endinterface

interface sceu_result_if;
	logic                      valid;
	logic                      ready;
	logic                      branch_taken;
	logic                      access_fault;
	logic [sceu_pkg::XLEN-1:0] written_value;

	modport source (output valid, branch_taken, access_fault, written_value, input ready);
	modport sink (input valid, branch_taken, access_fault, written_value, output ready);
endinterface

`default_nettype wire

// ===== rtl/sceu_front.sv =====
// Front end: accepts instructions and decodes them into queue entries.
// Depends on sceu_pkg and sceu_instr_if.
`default_nettype none

module sceu_front (
	sceu_instr_if.sink      instr,
	input  logic            q_full,
	output logic            q_push,
	output sceu_pkg::dec_t  q_item
);
	import sceu_pkg::*;

	assign instr.ready = !q_full;
	assign q_push      = instr.valid && !q_full;

	always_comb begin
		q_item             = '0;
		q_item.reg_i       = instr.reg_i;
		q_item.reg_j       = instr.reg_j;
		q_item.reg_k       = instr.reg_k;
		q_item.small_imm   = instr.small_imm;
		q_item.long_offset = instr.long_offset;
		q_item.wr_idx      = instr.reg_j;
		q_item.wr_en       = 1'b0;
		case (action_t'(instr.action))
			ACT_JMPZ: begin
				q_item.op = OP_JMPZ;
			end
			ACT_JMPP: begin
				q_item.op = OP_JMPP;
			end
			ACT_SETK: begin
				q_item.op    = OP_SETK;
				q_item.wr_en = 1'b1;
			end
			ACT_LOADRR: begin
				q_item.op     = OP_LOADRR;
				q_item.wr_en  = 1'b1;
				q_item.wr_idx = instr.reg_i;
			end
			ACT_STORERR: begin
				q_item.op = OP_STORERR;
			end
			ACT_ADDOC: begin
				q_item.op     = OP_ADDOC;
				q_item.wr_en  = 1'b1;
				q_item.wr_idx = instr.reg_i;
			end
			ACT_SUBIMM: begin
				q_item.op    = OP_SUBIMM;
				q_item.wr_en = 1'b1;
			end
			ACT_NEG: begin
				q_item.op    = OP_NEG;
				q_item.wr_en = 1'b1;
			end
			ACT_ADDIMM: begin
				q_item.op    = OP_ADDIMM;
				q_item.wr_en = 1'b1;
			end
			ACT_MUL: begin
				q_item.op    = OP_MUL;
				q_item.wr_en = 1'b1;
			end
			ACT_LOADK: begin
				q_item.op    = OP_LOADK;
				q_item.wr_en = 1'b1;
			end
			default: begin
				q_item.op = OP_NOP;
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== rtl/sceu_queue.sv =====
// Short FIFO of decoded instructions between front and back end.
// Depends on sceu_pkg.
`default_nettype none

module sceu_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  sceu_pkg::dec_t  din,
	output logic            full,
	input  logic            pop,
	output logic            head_valid,
	output sceu_pkg::dec_t  head
);
	import sceu_pkg::*;

	dec_t           entry_q [QDEPTH];
	logic [QAW-1:0] wr_ptr_q;
	logic [QAW-1:0] rd_ptr_q;
	logic [QAW:0]   count_q;
	logic           do_push;
	logic           do_pop;

	assign full       = (count_q == (QAW+1)'(QDEPTH));
	assign head_valid = (count_q != '0);
	assign head       = entry_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == QAW'(QDEPTH-1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QAW'(QDEPTH-1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/sceu_back.sv =====
// Back end: register file, data memory, shared 32x32 multiplier and the
// sequencer that executes one queued instruction at a time.
// Depends on sceu_pkg and sceu_result_if.
`default_nettype none

module sceu_back (
	input  logic             clk,
	input  logic             arst_n,
	input  sceu_pkg::cfg_t   cfg,
	input  logic             q_valid,
	input  sceu_pkg::dec_t   q_item,
	output logic             q_pop,
	sceu_result_if.source    result,
	output sceu_pkg::stat_t  stat
);
	import sceu_pkg::*;

	// register file: two registered read ports, valid bits give the reset value
	logic [XLEN-1:0]   rf_mem [NREGS];
	logic [NREGS-1:0]  rf_vld_q;
	logic [XLEN-1:0]   rf_rdata_a_q;
	logic [XLEN-1:0]   rf_rdata_b_q;
	logic              rf_va_q;
	logic              rf_vb_q;
	logic [RAW-1:0]    raddr_a;
	logic [RAW-1:0]    raddr_b;
	logic              rf_we;

	logic [XLEN-1:0]   dmem [MEM_WORDS];
	logic [XLEN-1:0]   dmem_rdata_q;
	logic [MEM_AW-1:0] maddr_q;
	logic              mem_we;
	logic              mem_re;

	bk_state_t         state_q;
	bk_state_t         state_d;
	dec_t              op_q;
	logic [XLEN-1:0]   prod_q;
	logic [HALF-1:0]   cross_q;

	logic              res_valid_q;
	logic              res_branch_q;
	logic              res_fault_q;
	logic [XLEN-1:0]   res_wval_q;

	logic [XLEN-1:0]   xa;
	logic [XLEN-1:0]   xb;
	logic [XLEN:0]     sum_x;
	logic [XLEN-1:0]   aoc_val;
	logic [XLEN-1:0]   imm_x;
	logic [BOUND_W-1:0] bound;
	logic [BOUND_W-1:0] rr_off;
	logic [BOUND_W-1:0] k_off;
	logic [BOUND_W-1:0] eff_off;
	logic [PADDR_W-1:0] paddr;
	logic              rr_fault;
	logic              st_fault;
	logic              k_fault;
	logic [HALF-1:0]   mul_a;
	logic [HALF-1:0]   mul_b;
	logic [XLEN-1:0]   mul_p;

	logic              out_free;
	logic              finish;
	logic              fin_branch;
	logic              fin_fault;
	logic [XLEN-1:0]   fin_wval;

	assign xa    = rf_va_q ? rf_rdata_a_q : '0;
	assign xb    = rf_vb_q ? rf_rdata_b_q : '0;
	assign sum_x = {1'b0, xa} + {1'b0, xb};
	// end-around carry: fold the carry out back into bit zero
	assign aoc_val = sum_x[XLEN-1:0] + XLEN'(sum_x[XLEN]);
	assign imm_x   = XLEN'(op_q.small_imm);

	assign bound  = {cfg.field_length, {UNIT_SH{1'b0}}};
	assign rr_off = BOUND_W'(sum_x[OFF_W-1:0]);
	assign k_off  = BOUND_W'(op_q.long_offset);
	assign rr_fault = (rr_off >= bound);
	assign k_fault  = (k_off >= bound);
	// negative or out-of-field store offset
	assign st_fault = sum_x[XLEN-1] || (|sum_x[XLEN-2:BOUND_W])
		|| (sum_x[BOUND_W-1:0] >= bound);

	always_comb begin
		case (op_q.op)
			OP_LOADRR:  eff_off = rr_off;
			OP_STORERR: eff_off = sum_x[BOUND_W-1:0];
			default:    eff_off = k_off;
		endcase
	end

	assign paddr = {{(PADDR_W-RB_W-UNIT_SH){1'b0}}, cfg.relocation_base, {UNIT_SH{1'b0}}}
		+ {{(PADDR_W-BOUND_W){1'b0}}, eff_off};

	assign mul_p    = mul_a * mul_b;
	assign out_free = !res_valid_q || result.ready;

	// sequencer outputs
	always_comb begin
		q_pop      = 1'b0;
		finish     = 1'b0;
		fin_branch = 1'b0;
		fin_fault  = 1'b0;
		fin_wval   = '0;
		mem_we     = 1'b0;
		mem_re     = 1'b0;
		raddr_a    = op_q.reg_j;
		raddr_b    = op_q.reg_k;
		mul_a      = xa[HALF-1:0];
		mul_b      = xb[HALF-1:0];
		case (state_q)
			BK_READ: begin
				q_pop   = q_valid;
				raddr_a = q_item.reg_j;
				raddr_b = q_item.reg_k;
			end
			BK_EXEC: begin
				case (op_q.op)
					OP_JMPZ: begin
						finish     = out_free;
						fin_branch = (xa == '0);
					end
					OP_JMPP: begin
						finish     = out_free;
						fin_branch = (xa != '0) && !xa[XLEN-1];
					end
					OP_SETK: begin
						finish   = out_free;
						fin_wval = imm_x;
					end
					OP_ADDOC: begin
						finish   = out_free;
						fin_wval = aoc_val;
					end
					OP_SUBIMM: begin
						finish   = out_free;
						fin_wval = xa - imm_x;
					end
					OP_NEG: begin
						finish   = out_free;
						fin_wval = '0 - xb;
					end
					OP_ADDIMM: begin
						finish   = out_free;
						fin_wval = xa + imm_x;
					end
					OP_LOADRR: begin
						if (rr_fault) begin
							finish    = out_free;
							fin_fault = 1'b1;
						end else begin
							mem_re = 1'b1;
						end
					end
					OP_LOADK: begin
						if (k_fault) begin
							finish    = out_free;
							fin_fault = 1'b1;
						end else begin
							mem_re = 1'b1;
						end
					end
					OP_STORERR: begin
						if (st_fault) begin
							finish    = out_free;
							fin_fault = 1'b1;
						end else begin
							raddr_a = op_q.reg_i;
						end
					end
					OP_MUL: begin
						// low partial product taken here, cross terms follow
					end
					default: begin
						finish = out_free;
					end
				endcase
			end
			BK_LOAD: begin
				finish   = out_free;
				fin_wval = dmem_rdata_q;
			end
			BK_STORE: begin
				raddr_a = op_q.reg_i;
				finish  = out_free;
				mem_we  = out_free;
			end
			BK_MUL_X1: begin
				mul_a = xa[HALF-1:0];
				mul_b = xb[XLEN-1:HALF];
			end
			BK_MUL_X2: begin
				mul_a = xa[XLEN-1:HALF];
				mul_b = xb[HALF-1:0];
			end
			BK_MUL_FIN: begin
				finish   = out_free;
				fin_wval = prod_q + {cross_q, {HALF{1'b0}}};
			end
			default: begin
			end
		endcase
	end

	assign rf_we      = finish && op_q.wr_en && !fin_fault;
	assign stat.fault = finish && fin_fault;

	// sequencer next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			BK_READ: begin
				if (q_valid) begin
					state_d = BK_EXEC;
				end
			end
			BK_EXEC: begin
				if (finish) begin
					state_d = BK_READ;
				end else if (mem_re) begin
					state_d = BK_LOAD;
				end else if (op_q.op == OP_STORERR && !st_fault) begin
					state_d = BK_STORE;
				end else if (op_q.op == OP_MUL) begin
					state_d = BK_MUL_X1;
				end
			end
			BK_LOAD, BK_STORE, BK_MUL_FIN: begin
				if (finish) begin
					state_d = BK_READ;
				end
			end
			BK_MUL_X1: begin
				state_d = BK_MUL_X2;
			end
			BK_MUL_X2: begin
				state_d = BK_MUL_FIN;
			end
			default: begin
				state_d = BK_READ;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (rf_we) begin
			rf_mem[op_q.wr_idx] <= fin_wval;
		end
		rf_rdata_a_q <= rf_mem[raddr_a];
		rf_rdata_b_q <= rf_mem[raddr_b];
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			dmem[maddr_q] <= xa;
		end
		if (mem_re) begin
			dmem_rdata_q <= dmem[paddr[MEM_AW-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			op_q <= q_item;
		end
		if (state_q == BK_EXEC) begin
			maddr_q <= paddr[MEM_AW-1:0];
			prod_q  <= mul_p;
		end
		if (state_q == BK_MUL_X1) begin
			cross_q <= mul_p[HALF-1:0];
		end else if (state_q == BK_MUL_X2) begin
			cross_q <= cross_q + mul_p[HALF-1:0];
		end
		if (finish) begin
			res_branch_q <= fin_branch;
			res_fault_q  <= fin_fault;
			res_wval_q   <= fin_wval;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_READ;
			rf_vld_q    <= '0;
			rf_va_q     <= 1'b0;
			rf_vb_q     <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (rf_we) begin
				rf_vld_q[op_q.wr_idx] <= 1'b1;
			end
			rf_va_q <= rf_vld_q[raddr_a];
			rf_vb_q <= rf_vld_q[raddr_b];
			if (finish) begin
				res_valid_q <= 1'b1;
			end else if (result.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	assign result.valid         = res_valid_q;
	assign result.branch_taken  = res_branch_q;
	assign result.access_fault  = res_fault_q;
	assign result.written_value = res_wval_q;

endmodule

`default_nettype wire

// ===== rtl/scalar_execute_unit_bounds_checked.sv =====
// Scalar execute unit with bounds-checked, relocated memory access.
//
// Instructions arrive on the instr channel (valid/ready); one result per
// instruction leaves on the result channel in the same order. Field length,
// relocation base and exchange address are set through the cfg_wr_en /
// cfg_index / cfg_data write port; the user must write them only while no
// instruction is in flight; the block itself does not enforce this.
// The back end executes one instruction at a time and takes the next one
// from the queue only after the current one has finished, so a result also
// waits while the back end is still busy with earlier instructions. Each
// instruction reads the register file through its registered read ports
// before it executes; a load adds the registered data memory read, a store
// a second register read, and a multiply three passes through the shared
// 32x32 multiplier.
// Reset clears the register file, the configuration, the sticky fault flag
// and the queue. A stalled result is held in its output register; the back
// end finishes the next instruction up to its result and waits, and the
// two-entry queue keeps accepting until it fills, then ready drops.
`default_nettype none

module scalar_execute_unit_bounds_checked (
	input  logic                        clk,
	input  logic                        arst_n,
	sceu_instr_if.sink                  instr,
	sceu_result_if.source               result,
	input  logic                        cfg_wr_en,
	input  logic [sceu_pkg::CFG_IW-1:0] cfg_index,
	input  logic [sceu_pkg::CFG_DW-1:0] cfg_data
);
	import sceu_pkg::*;

	cfg_t             cfg_q;
	stat_t            stat;
	logic             fault_flag_q;
	logic [OFF_W-1:0] saved_exch_q;

	logic             q_full;
	logic             q_push;
	dec_t             q_din;
	logic             q_pop;
	logic             q_valid;
	dec_t             q_head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q        <= '0;
			fault_flag_q <= 1'b0;
			saved_exch_q <= '0;
		end else begin
			if (cfg_wr_en) begin
				case (cfg_idx_t'(cfg_index))
					CFG_FIELD_LENGTH:     cfg_q.field_length     <= cfg_data[FL_W-1:0];
					CFG_RELOCATION_BASE:  cfg_q.relocation_base  <= cfg_data[RB_W-1:0];
					CFG_EXCHANGE_ADDRESS: cfg_q.exchange_address <= cfg_data[OFF_W-1:0];
					default: begin
					end
				endcase
			end
			// sticky fault, capture exchange address
			if (stat.fault) begin
				fault_flag_q <= 1'b1;
				saved_exch_q <= cfg_q.exchange_address;
			end
		end
	end

	sceu_front u_front (
		.instr  (instr),
		.q_full (q_full),
		.q_push (q_push),
		.q_item (q_din)
	);

	sceu_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.din        (q_din),
		.full       (q_full),
		.pop        (q_pop),
		.head_valid (q_valid),
		.head       (q_head)
	);

	sceu_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.q_valid (q_valid),
		.q_item  (q_head),
		.q_pop   (q_pop),
		.result  (result),
		.stat    (stat)
	);

`ifndef ASSERT_OFF
	a_fault_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.access_fault) |-> fault_flag_q)
		else $error("faulting result delivered without sticky fault flag");

	a_exch_clean: assert property (@(posedge clk) disable iff (!arst_n)
		!fault_flag_q |-> (saved_exch_q == '0))
		else $error("exchange address captured without a fault");

	a_branch_only: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.branch_taken)
		|-> (!result.access_fault && result.written_value == '0))
		else $error("taken branch result carries fault or write value");
`endif

endmodule

`default_nettype wire

// ===== dv/tb_scalar_execute_unit_bounds_checked.sv =====
`timescale 1ns / 100ps
// Testbench for scalar_execute_unit_bounds_checked: drives instruction transfers, predicts
// each result from a private copy of registers, memory and bound settings, and checks them.
// Depends on sceu_pkg and the channel interfaces in sceu_ifs.sv.

module tb_scalar_execute_unit_bounds_checked;
	import sceu_pkg::*;

	localparam logic [ACT_W-1:0] ACT_UNUSED_FIRST = 4'd11;
	localparam logic [ACT_W-1:0] ACT_UNUSED_LAST  = 4'd15;
	localparam logic [63:0]      OFFSET_MASK      = 64'hfffff;

	typedef struct {
		logic [ACT_W-1:0] action;
		logic [RAW-1:0]   reg_i;
		logic [RAW-1:0]   reg_j;
		logic [RAW-1:0]   reg_k;
		logic [IMM_W-1:0] small_imm;
		logic [OFF_W-1:0] long_offset;
	} instr_t;

	typedef struct {
		logic            branch_taken;
		logic            access_fault;
		logic [XLEN-1:0] written_value;
	} exec_result_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_wr_en;
	logic [CFG_IW-1:0] cfg_index;
	logic [CFG_DW-1:0] cfg_data;

	sceu_instr_if  instr_ch ();
	sceu_result_if result_ch ();

	scalar_execute_unit_bounds_checked i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.instr     (instr_ch),
		.result    (result_ch),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// predicted architectural state
	logic [XLEN-1:0] gpr [NREGS];
	logic [XLEN-1:0] mem_image [int unsigned];
	int unsigned     written_addrs [$];
	logic            sticky_fault;
	logic [OFF_W-1:0] captured_exchange;
	logic [FL_W-1:0] cur_field_length;
	logic [RB_W-1:0] cur_reloc_base;
	logic [OFF_W-1:0] cur_exchange;

	exec_result_t pending_results [$];
	int unsigned  instr_sent;
	int unsigned  mismatch_count;
	bit           quiet_mode;
	int           hold_request;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	initial begin
		#(12_000_000);
		$display("CHECK FAILED");
		$finish;
	end

	function automatic logic [3:0] rnd4();
		return 4'($urandom);
	endfunction

	function automatic int pick_gap();
		int roll;
		if (quiet_mode)
			return 0;
		roll = $urandom_range(0, 99);
		if (roll < 45)
			return 0;
		if (roll < 85)
			return $urandom_range(1, 3);
		if (roll < 96)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [63:0] access_bound();
		return 64'(cur_field_length) << UNIT_SH;
	endfunction

	function automatic int unsigned phys_addr(logic [63:0] off);
		return int'(((64'(cur_reloc_base) << UNIT_SH) + off) % MEM_WORDS);
	endfunction

	function automatic void note_fault();
		sticky_fault = 1'b1;
		captured_exchange = cur_exchange;
	endfunction

	// A load that passes its bound check must hit a word written earlier.
	function automatic bit reads_unwritten(instr_t it);
		logic [63:0] off;
		if (it.action == ACT_LOADRR)
			off = (gpr[it.reg_j] + gpr[it.reg_k]) & OFFSET_MASK;
		else if (it.action == ACT_LOADK)
			off = 64'(it.long_offset);
		else
			return 1'b0;
		return off < access_bound() && !mem_image.exists(phys_addr(off));
	endfunction

	function automatic exec_result_t execute_instr(instr_t it);
		exec_result_t r;
		logic [63:0] xj, xk, off;
		logic [64:0] wide;
		int unsigned pa;
		xj = gpr[it.reg_j];
		xk = gpr[it.reg_k];
		r.branch_taken = 1'b0;
		r.access_fault = 1'b0;
		r.written_value = '0;
		case (it.action)
			ACT_JMPZ: r.branch_taken = (xj == 0);
			ACT_JMPP: r.branch_taken = (xj != 0) && !xj[63];
			ACT_SETK: begin
				r.written_value = 64'(it.small_imm);
				gpr[it.reg_j] = r.written_value;
			end
			ACT_LOADRR: begin
				off = (xj + xk) & OFFSET_MASK;
				if (off >= access_bound()) begin
					note_fault();
					r.access_fault = 1'b1;
				end else begin
					r.written_value = mem_image[phys_addr(off)];
					gpr[it.reg_i] = r.written_value;
				end
			end
			ACT_STORERR: begin
				off = xj + xk;
				if (off[63] || off >= access_bound()) begin
					note_fault();
					r.access_fault = 1'b1;
				end else begin
					pa = phys_addr(off);
					if (!mem_image.exists(pa))
						written_addrs.push_back(pa);
					mem_image[pa] = gpr[it.reg_i];
				end
			end
			ACT_ADDOC: begin
				// end-around carry: fold the carry out back into bit 0
				wide = {1'b0, xj} + {1'b0, xk};
				r.written_value = wide[63:0] + 64'(wide[64]);
				gpr[it.reg_i] = r.written_value;
			end
			ACT_SUBIMM: begin
				r.written_value = xj - 64'(it.small_imm);
				gpr[it.reg_j] = r.written_value;
			end
			ACT_NEG: begin
				r.written_value = 64'd0 - xk;
				gpr[it.reg_j] = r.written_value;
			end
			ACT_ADDIMM: begin
				r.written_value = xj + 64'(it.small_imm);
				gpr[it.reg_j] = r.written_value;
			end
			ACT_MUL: begin
				r.written_value = xj * xk;
				gpr[it.reg_j] = r.written_value;
			end
			ACT_LOADK: begin
				off = 64'(it.long_offset);
				if (off >= access_bound()) begin
					note_fault();
					r.access_fault = 1'b1;
				end else begin
					r.written_value = mem_image[phys_addr(off)];
					gpr[it.reg_j] = r.written_value;
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	function automatic instr_t instr_of(logic [ACT_W-1:0] act, logic [RAW-1:0] ri,
			logic [RAW-1:0] rj, logic [RAW-1:0] rk, logic [IMM_W-1:0] imm,
			logic [OFF_W-1:0] off);
		instr_t it;
		it.action = act;
		it.reg_i = ri;
		it.reg_j = rj;
		it.reg_k = rk;
		it.small_imm = imm;
		it.long_offset = off;
		return it;
	endfunction

	task automatic send_instr(instr_t it);
		int gap;
		if (reads_unwritten(it))
			it.action = ACT_JMPZ;
		gap = pick_gap();
		if (gap > 0) begin
			@(negedge clk);
			instr_ch.valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		instr_ch.action      <= it.action;
		instr_ch.reg_i       <= it.reg_i;
		instr_ch.reg_j       <= it.reg_j;
		instr_ch.reg_k       <= it.reg_k;
		instr_ch.small_imm   <= it.small_imm;
		instr_ch.long_offset <= it.long_offset;
		instr_ch.valid       <= 1'b1;
		do @(posedge clk); while (instr_ch.ready !== 1'b1);
		pending_results.push_back(execute_instr(it));
		instr_sent++;
	endtask

	task automatic wait_results_drained();
		@(negedge clk);
		instr_ch.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_config(cfg_idx_t idx, logic [CFG_DW-1:0] data);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		case (idx)
			CFG_FIELD_LENGTH:     cur_field_length = data[FL_W-1:0];
			CFG_RELOCATION_BASE:  cur_reloc_base = data[RB_W-1:0];
			CFG_EXCHANGE_ADDRESS: cur_exchange = data[OFF_W-1:0];
			default: ;
		endcase
	endtask

	// Only touch the settings once the unit has gone idle.
	task automatic apply_settings(logic [FL_W-1:0] fl, logic [RB_W-1:0] rb,
			logic [OFF_W-1:0] ea);
		logic [CFG_DW-1:0] junk;
		wait_results_drained();
		junk = CFG_DW'($urandom);
		write_config(CFG_FIELD_LENGTH, {junk[CFG_DW-1:FL_W], fl});
		junk = CFG_DW'($urandom);
		write_config(CFG_RELOCATION_BASE, {junk[CFG_DW-1:RB_W], rb});
		write_config(CFG_EXCHANGE_ADDRESS, ea);
	endtask

	// Load small offsets, store through them and read the word back.
	task automatic run_access_sequence();
		logic [RAW-1:0] rj, rk;
		int unsigned p, loff;
		rj = rnd4();
		rk = rnd4();
		send_instr(instr_of(ACT_SETK, rnd4(), rj, rnd4(), rnd4(), 20'($urandom)));
		send_instr(instr_of(ACT_SETK, rnd4(), rk, rnd4(), rnd4(), 20'($urandom)));
		if ($urandom_range(0, 2) == 0)
			send_instr(instr_of(ACT_MUL, rnd4(), rj, rk, rnd4(), 20'($urandom)));
		if ($urandom_range(0, 3) == 0)
			send_instr(instr_of(ACT_MUL, rnd4(), rj, rj, rnd4(), 20'($urandom)));
		if ($urandom_range(0, 3) == 0)
			send_instr(instr_of(ACT_ADDIMM, rnd4(), rj, rnd4(), rnd4(), 20'($urandom)));
		if ($urandom_range(0, 7) == 0)
			send_instr(instr_of(ACT_NEG, rnd4(), rj, rj, rnd4(), 20'($urandom)));
		send_instr(instr_of(ACT_STORERR, rnd4(), rj, rk, rnd4(), 20'($urandom)));
		send_instr(instr_of(ACT_LOADRR, rnd4(), rj, rk, rnd4(), 20'($urandom)));
		if (written_addrs.size() > 0) begin
			p = written_addrs[$urandom_range(0, written_addrs.size() - 1)];
			loff = (p + 16 * MEM_WORDS - (32'(cur_reloc_base) << UNIT_SH)) % MEM_WORDS;
			if ($urandom_range(0, 1) == 1)
				loff += $urandom_range(0, 15) * MEM_WORDS;
		end else begin
			loff = $urandom;
		end
		send_instr(instr_of(ACT_LOADK, rnd4(), rnd4(), rnd4(), rnd4(), 20'(loff)));
	endtask

	task automatic send_noise();
		send_instr(instr_of(rnd4(), rnd4(), rnd4(), rnd4(), rnd4(), 20'($urandom)));
	endtask

	// Reset settings give a zero bound, so every access must fault.
	task automatic test_unconfigured_bounds();
		send_instr(instr_of(ACT_JMPZ, 4'd0, 4'd0, 4'd0, 4'd0, 20'd0));
		send_instr(instr_of(ACT_JMPP, 4'd0, 4'd0, 4'd0, 4'd0, 20'd0));
		send_instr(instr_of(ACT_LOADK, 4'd1, 4'd1, 4'd0, 4'd0, 20'd0));
		send_instr(instr_of(ACT_STORERR, 4'd0, 4'd0, 4'd0, 4'd0, 20'd0));
		send_instr(instr_of(ACT_UNUSED_FIRST, 4'hf, 4'hf, 4'hf, 4'hf, 20'hfffff));
		send_instr(instr_of(ACT_UNUSED_LAST, 4'hf, 4'hf, 4'hf, 4'hf, 20'hfffff));
	endtask

	task automatic test_alu_extremes();
		send_instr(instr_of(ACT_SETK, 4'd0, 4'd1, 4'd0, 4'hf, 20'd0));
		send_instr(instr_of(ACT_NEG, 4'd0, 4'd2, 4'd1, 4'd0, 20'd0));
		send_instr(instr_of(ACT_JMPP, 4'd0, 4'd2, 4'd0, 4'd0, 20'd0));
		send_instr(instr_of(ACT_JMPP, 4'd0, 4'd1, 4'd0, 4'd0, 20'd0));
		// both operands near all ones: carry out wraps into bit 0
		send_instr(instr_of(ACT_ADDOC, 4'd3, 4'd2, 4'd2, 4'd0, 20'd0));
		send_instr(instr_of(ACT_MUL, 4'd0, 4'd2, 4'd2, 4'd0, 20'd0));
		send_instr(instr_of(ACT_SUBIMM, 4'd0, 4'd4, 4'd0, 4'hf, 20'd0));
		send_instr(instr_of(ACT_ADDIMM, 4'd0, 4'd4, 4'd0, 4'hf, 20'd0));
		send_instr(instr_of(ACT_JMPZ, 4'd0, 4'd4, 4'd0, 4'd0, 20'd0));
	endtask

	// One 256-word field at the top base: the last word wraps to the end of memory.
	task automatic test_bound_edges();
		apply_settings(13'd1, 12'hfff, 20'hfffff);
		send_instr(instr_of(ACT_SETK, 4'd0, 4'd5, 4'd0, 4'hf, 20'd0));
		send_instr(instr_of(ACT_MUL, 4'd0, 4'd5, 4'd5, 4'd0, 20'd0));
		send_instr(instr_of(ACT_SETK, 4'd0, 4'd6, 4'd0, 4'hf, 20'd0));
		send_instr(instr_of(ACT_ADDIMM, 4'd0, 4'd6, 4'd0, 4'hf, 20'd0));
		send_instr(instr_of(ACT_STORERR, 4'd3, 4'd5, 4'd6, 4'd0, 20'd0));
		send_instr(instr_of(ACT_LOADRR, 4'd7, 4'd5, 4'd6, 4'd0, 20'd0));
		send_instr(instr_of(ACT_LOADK, 4'd0, 4'd8, 4'd0, 4'd0, 20'd255));
		send_instr(instr_of(ACT_LOADK, 4'd0, 4'd8, 4'd0, 4'd0, 20'd256));
		send_instr(instr_of(ACT_ADDIMM, 4'd0, 4'd6, 4'd0, 4'd1, 20'd0));
		send_instr(instr_of(ACT_STORERR, 4'd3, 4'd5, 4'd6, 4'd0, 20'd0));
		// negative offset on a store
		send_instr(instr_of(ACT_NEG, 4'd0, 4'd9, 4'd5, 4'd0, 20'd0));
		send_instr(instr_of(ACT_STORERR, 4'd3, 4'd9, 4'd0, 4'd0, 20'd0));
		send_instr(instr_of(ACT_LOADRR, 4'd10, 4'd5, 4'd6, 4'd0, 20'd0));
	endtask

	task automatic test_random_settings();
		int unsigned start;
		logic [FL_W-1:0] fl;
		logic [RB_W-1:0] rb;
		logic [OFF_W-1:0] ea;
		for (int phase = 0; phase < 6; phase++) begin
			rb = 12'($urandom);
			ea = 20'($urandom);
			case (phase)
				0: begin
					fl = 13'd4096;
					rb = '0;
				end
				1: begin
					fl = 13'h1fff;
					rb = 12'hfff;
					ea = 20'hfffff;
				end
				2: begin
					fl = '0;
					ea = '0;
				end
				default: fl = 13'($urandom_range(1, 300));
			endcase
			apply_settings(fl, rb, ea);
			start = instr_sent;
			while (instr_sent - start < 115) begin
				quiet_mode = ($urandom_range(0, 4) == 0);
				if ($urandom_range(0, 3) == 0)
					send_noise();
				else
					run_access_sequence();
			end
		end
		quiet_mode = 1'b0;
	endtask

	// Stall the result side long enough for the queue to fill and ready to drop.
	task automatic test_result_backpressure();
		apply_settings(13'd64, 12'($urandom), 20'($urandom));
		quiet_mode = 1'b1;
		hold_request = 160;
		repeat (4) run_access_sequence();
		wait_results_drained();
		quiet_mode = 1'b0;
		repeat (3) run_access_sequence();
	endtask

	initial begin : result_acceptor
		int stall_left;
		stall_left = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (hold_request > 0) begin
				stall_left = hold_request;
				hold_request = 0;
			end
			if (stall_left > 0) begin
				result_ch.ready <= 1'b0;
				stall_left--;
			end else begin
				result_ch.ready <= 1'b1;
				stall_left = pick_gap();
			end
		end
	end

	task automatic note_mismatch(string field, logic [63:0] want, logic [63:0] got);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("mismatch on %s: expected %h, got %h", field, want, got);
	endtask

	always @(posedge clk) begin : result_check
		exec_result_t want;
		if (arst_n === 1'b1 && result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
			if (pending_results.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("result transfer with no instruction outstanding");
			end else begin
				want = pending_results.pop_front();
				if (result_ch.branch_taken !== want.branch_taken)
					note_mismatch("branch_taken", 64'(want.branch_taken),
						64'(result_ch.branch_taken));
				if (result_ch.access_fault !== want.access_fault)
					note_mismatch("access_fault", 64'(want.access_fault),
						64'(result_ch.access_fault));
				if (result_ch.written_value !== want.written_value)
					note_mismatch("written_value", want.written_value,
						result_ch.written_value);
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		instr_ch.valid = 1'b0;
		instr_ch.action = '0;
		instr_ch.reg_i = '0;
		instr_ch.reg_j = '0;
		instr_ch.reg_k = '0;
		instr_ch.small_imm = '0;
		instr_ch.long_offset = '0;
		result_ch.ready = 1'b0;
		for (int r = 0; r < NREGS; r++)
			gpr[r] = '0;
		sticky_fault = 1'b0;
		captured_exchange = '0;
		cur_field_length = '0;
		cur_reloc_base = '0;
		cur_exchange = '0;
		instr_sent = 0;
		mismatch_count = 0;
		quiet_mode = 1'b0;
		hold_request = 0;

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_unconfigured_bounds();
		test_alu_extremes();
		test_bound_edges();
		test_random_settings();
		test_result_backpressure();

		wait_results_drained();
		repeat (20) @(posedge clk);
		// sticky fault state after the last transfer
		if (i_dut.fault_flag_q !== sticky_fault)
			note_mismatch("fault_flag", 64'(sticky_fault), 64'(i_dut.fault_flag_q));
		if (i_dut.saved_exch_q !== captured_exchange)
			note_mismatch("saved_exchange", 64'(captured_exchange),
				64'(i_dut.saved_exch_q));
		if (mismatch_count == 0 && pending_results.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
